// File: hdl/sha256_stream_hasher_assert.svh
// Assertion macros for the stream hasher.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHS_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define SHS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// File: hdl/shs_pkg.sv
package shs_pkg;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [63:0] BITS_PER_BLOCK = 64'd512;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } shs_core_ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// File: hdl/shs_core.sv
// Compression engine: one round per cycle. Message words are read from the
// block memory (one 32-bit word per cycle, through a registered read) for rounds 0..15
// and expanded in a 16-word shift window after that.
module shs_core
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       mem_word,
    output logic [3:0]        mem_addr,
    input  logic [255:0]      hash_in,
    output logic [255:0]      hash_out,
    output shs_core_ctl_t     ctl
);
    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_ADD   = 3'b100
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] wt, s0, s1, big0, big1, ch, maj, t1, t2;
    logic [255:0] sum;

    // Prefetch word t+1 while round t runs.
    assign mem_addr = (state_reg == C_IDLE) ? 4'd0 : cnt_next[3:0];

    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt = (cnt_reg < 7'd16) ? mem_word : (s1 + w_reg[9] + s0 + w_reg[0]);
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + big1 + ch + ROUND_K[cnt_reg[5:0]] + wt;
        t2 = big0 + maj;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_ROUND;
                    cnt_next   = 7'd0;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_next[i] = hash_in[255 - 32*i -: 32];
                    end
                end
            end
            C_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = wt;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sum[255 - 32*i -: 32] = hash_in[255 - 32*i -: 32] + v_reg[i];
        end
    end
    assign hash_out = sum;

    assign ctl.start = start && (state_reg == C_IDLE);
    assign ctl.busy  = (state_reg != C_IDLE);
    assign ctl.done  = (state_reg == C_ADD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule

// File: hdl/sha256_stream_hasher.sv
// SHA-256 over a byte stream.
// Input channel (in_valid/in_stall): data_byte, has_byte, end_of_message.
// A byte item is taken and written into a 16-word block memory (one word
// read, one word written per cycle; the read port is registered).
// The 64th byte starts a compression of 64 rounds and a final add step,
// during which in_stall is high. An end-of-message item pads the block in
// a memory sweep up to word 15, compresses once or twice, then emits eight
// result items, word 0 first, on out_valid/out_stall; word_index counts 0..7
// and last_word marks the eighth. Throughput is one byte per cycle between
// blocks. A stalled receiver holds the current word; the input stays stalled
// until the last word is taken. Reset restores the initial hash values, a
// zero fill count and a zero bit count; the block memory needs no clearing.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
`include "sha256_stream_hasher_assert.svh"

    typedef enum logic [5:0] {
        S_IN    = 6'b000001,
        S_COMP  = 6'b000010,
        S_PAD   = 6'b000100,
        S_FCOMP = 6'b001000,
        S_WAIT  = 6'b010000,
        S_OUT   = 6'b100000
    } top_state_t;

    top_state_t    state_reg, state_next;
    logic [255:0]  hash_reg, hash_next;
    logic [6:0]    fill_reg, fill_next;
    logic [63:0]   bits_reg, bits_next;
    logic [3:0]    pidx_reg, pidx_next;
    logic          second_reg, second_next;
    logic [2:0]    oidx_reg, oidx_next;

    logic [31:0]   mem [16];
    logic [31:0]   rd_data_reg;
    logic [3:0]    rd_addr;
    logic          we;
    logic [3:0]    wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   word_reg;

    logic          core_start;
    logic [3:0]    core_addr;
    logic [255:0]  core_out;
    shs_core_ctl_t core_ctl;

    logic          acc;
    logic [5:0]    fpos;
    logic [31:0]   pad_word;
    logic          out_take;

    assign acc      = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign in_stall = (state_reg != S_IN);
    assign fpos     = fill_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Byte lanes are assembled in a word register; the full word is written
    // back on every byte so the memory always holds the current block.
    always_comb
    begin
        pad_word = 32'd0;
        for (int b = 0; b < 4; b++)
        begin
            if ({pidx_reg, 2'(b)} < fpos)
            begin
                pad_word[31 - 8*b -: 8] = word_reg[31 - 8*b -: 8];
            end
            else if ({pidx_reg, 2'(b)} == fpos && !second_reg)
            begin
                pad_word[31 - 8*b -: 8] = PAD_BYTE;
            end
        end
        if (pidx_reg == 4'd14 && fill_reg < 7'(LEN_POS))
        begin
            pad_word = bits_reg[63:32];
        end
        if (pidx_reg == 4'd15 && fill_reg < 7'(LEN_POS))
        begin
            pad_word = bits_reg[31:0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        pidx_next   = pidx_reg;
        second_next = second_reg;
        oidx_next   = oidx_reg;
        we          = 1'b0;
        wr_addr     = fpos[5:2];
        wr_data     = word_reg;
        core_start  = 1'b0;
        rd_addr     = core_addr;
        unique case (state_reg)
            S_IN:
            begin
                if (acc)
                begin
                    if (has_byte)
                    begin
                        we = 1'b1;
                        wr_data = word_reg;
                        wr_data[31 - 8*fpos[1:0] -: 8] = data_byte;
                        fill_next = fill_reg + 7'd1;
                    end
                    if (has_byte && fill_reg == 7'd63)
                    begin
                        core_start = 1'b1;
                        state_next = S_COMP;
                        second_next = end_of_message;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                        pidx_next  = fill_next[5:2];
                        bits_next  = bits_reg + {54'd0, fill_next, 3'd0};
                        second_next = 1'b0;
                    end
                end
            end
            S_COMP:
            begin
                if (core_ctl.done)
                begin
                    hash_next = core_out;
                    bits_next = bits_reg + BITS_PER_BLOCK;
                    fill_next = 7'd0;
                    if (second_reg)
                    begin
                        state_next  = S_PAD;
                        pidx_next   = 4'd0;
                        second_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IN;
                    end
                end
            end
            S_PAD:
            begin
                // Sweep from the word holding the pad byte (word 0 for an extra length block) to the end.
                we      = 1'b1;
                wr_addr = pidx_reg;
                wr_data = pad_word;
                pidx_next = pidx_reg + 4'd1;
                if (pidx_reg == 4'd15)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                core_start = 1'b1;
                state_next = S_FCOMP;
            end
            S_FCOMP:
            begin
                if (core_ctl.done)
                begin
                    hash_next = core_out;
                    if (fill_reg >= 7'(LEN_POS))
                    begin
                        // Length did not fit: one more block of zeros and length.
                        fill_next   = 7'd0;
                        second_next = 1'b1;
                        pidx_next   = 4'd0;
                        state_next  = S_PAD;
                    end
                    else
                    begin
                        oidx_next  = 3'd0;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = S_IN;
                        fill_next  = 7'd0;
                        bits_next  = 64'd0;
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[255 - 32*i -: 32] = INIT_HASH[i];
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // word_reg caches the partial word being filled.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IN && acc && has_byte)
        begin
            word_reg <= (fpos[1:0] == 2'd3) ? 32'd0 : wr_data;
        end
        else if (state_reg == S_IN && acc && end_of_message)
        begin
            word_reg <= word_reg;
        end
        else if (state_reg == S_OUT || (state_reg == S_COMP && core_ctl.done))
        begin
            word_reg <= 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            fill_reg   <= 7'd0;
            bits_reg   <= 64'd0;
            pidx_reg   <= 4'd0;
            second_reg <= 1'b0;
            oidx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[255 - 32*i -: 32] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            pidx_reg   <= pidx_next;
            second_reg <= second_next;
            oidx_reg   <= oidx_next;
            hash_reg   <= hash_next;
        end
    end

    shs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (core_start),
        .mem_word (rd_data_reg),
        .mem_addr (core_addr),
        .hash_in  (hash_reg),
        .hash_out (core_out),
        .ctl      (core_ctl)
    );

    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = hash_reg[255 - 32*oidx_reg -: 32];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    `SHS_ASSERT_IMPL(a_no_out_while_input, clk, rst_n, out_valid, in_stall)
    `SHS_ASSERT_IMPL(a_core_only_when_busy, clk, rst_n, core_ctl.busy,
        state_reg == S_COMP || state_reg == S_FCOMP)
    `SHS_ASSERT_NEXT(a_core_starts, clk, rst_n, core_ctl.start, core_ctl.busy)
    `SHS_ASSERT_NEXT(a_last_returns, clk, rst_n, out_take && last_word,
        !out_valid && fill_reg == 7'd0)
    `SHS_ASSERT_IMPL(a_fill_bound, clk, rst_n, state_reg == S_IN, fill_reg < 7'd64)
endmodule
